### rtl/core/disk_potential_force_eval_assert.svh
// assertion macros shared by the disk potential evaluator
`ifndef DISK_POTENTIAL_FORCE_EVAL_ASSERT_SVH
`define DISK_POTENTIAL_FORCE_EVAL_ASSERT_SVH
// condition that must hold on the same edge
`define DPFE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// condition that must hold a fixed number of cycles later
`define DPFE_ASSERT_AFTER(label, ante, cycles, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(cycles) (cons)) \
    else $error(msg);
`endif

### rtl/core/dpfe_pkg.sv
`timescale 1ns / 1ps
package dpfe_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int EXP_BITS   = 12;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 33;
  localparam int LATENCY    = 9 + 2 * SQRT_STEPS + 2 * DIV_STEPS;

  localparam logic [2:0] OP_POT = 3'd0;
  localparam logic [2:0] OP_FR  = 3'd1;
  localparam logic [2:0] OP_FZ  = 3'd2;
  localparam logic [2:0] OP_PFR = 3'd3;
  localparam logic [2:0] OP_PR2 = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;

  localparam logic [1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [1:0] REG_RADIAL    = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  localparam logic [31:0] AMP_RESET    = 32'd65536;
  localparam logic [30:0] RADIAL_RESET = 31'd65536;
  localparam logic [30:0] HEIGHT_RESET = 31'd6554;

  localparam logic [63:0] POS_LIMIT = (64'd1 << (WORD_BITS - 1)) - 64'd1;
  localparam logic [63:0] NEG_LIMIT = 64'd1 << (WORD_BITS - 1);

  typedef logic signed [EXP_BITS-1:0] exp_t;

  // magnitude: 32-bit significand with top bit set, or zero
  typedef struct packed {
    logic [31:0] m;
    exp_t        e;
  } flt_t;

  typedef struct packed {
    logic [2:0] op;
    logic       undef;
    logic       aneg;
    logic       rneg;
    logic       zneg;
    logic       dneg;
    flt_t       amp;
    flt_t       r;
    flt_t       z;
    flt_t       a;
    flt_t       b;
    flt_t       r2;
    flt_t       z2;
    flt_t       b2;
    flt_t       t;
    flt_t       s;
    flt_t       as;
    flt_t       as2;
    flt_t       ratio;
    flt_t       den;
    flt_t       sd;
    flt_t       d3;
    flt_t       ar;
    flt_t       az;
    flt_t       dd;
    flt_t       diff;
    flt_t       d5;
    flt_t       ad;
    flt_t       num2;
    flt_t       num;
    flt_t       dnm;
  } ctx_t;

  typedef struct packed {
    logic [32:0] w;
    logic [31:0] y;
    logic [32:0] q;
  } div_work_t;

  typedef struct packed {
    logic [63:0] v;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_work_t;

  function automatic logic [4:0] lead_zeros(input logic [31:0] x);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && x[i]) begin
        n = 5'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] mag_of(input logic [31:0] raw);
    return raw[WORD_BITS-1] ? (~raw) + 32'd1 : raw;
  endfunction

  function automatic flt_t from_mag(input logic [31:0] mag);
    flt_t       r;
    logic [4:0] lz;
    lz = lead_zeros(mag);
    r = '0;
    if (mag != '0) begin
      r.m = mag << lz;
      r.e = exp_t'(-FRAC_BITS) - exp_t'(lz);
    end
    return r;
  endfunction

  function automatic flt_t fmul(input flt_t x, input flt_t y);
    flt_t        r;
    logic [63:0] p;
    p = {32'd0, x.m} * {32'd0, y.m};
    r = '0;
    if (x.m != '0 && y.m != '0) begin
      if (p[63]) begin
        r.m = p[63:32];
        r.e = x.e + y.e + exp_t'(32);
      end else begin
        r.m = p[62:31];
        r.e = x.e + y.e + exp_t'(31);
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] align(input flt_t big, input flt_t sml);
    exp_t        d;
    logic [31:0] res;
    d = big.e - sml.e;
    if (sml.m == '0 || d > exp_t'(31)) res = '0;
    else res = sml.m >> d[4:0];
    return res;
  endfunction

  function automatic flt_t fadd(input flt_t x, input flt_t y);
    flt_t        big;
    flt_t        sml;
    flt_t        r;
    logic [32:0] sum;
    if (y.e > x.e) begin
      big = y;
      sml = x;
    end else begin
      big = x;
      sml = y;
    end
    sum = {1'b0, big.m} + {1'b0, align(big, sml)};
    if (x.m == '0) r = y;
    else if (y.m == '0) r = x;
    else if (sum[32]) begin
      r.m = sum[32:1];
      r.e = big.e + exp_t'(1);
    end else begin
      r.m = sum[31:0];
      r.e = big.e;
    end
    return r;
  endfunction

  // x must not be below y
  function automatic flt_t fsub(input flt_t x, input flt_t y);
    flt_t        r;
    logic [31:0] diff;
    logic [4:0]  lz;
    diff = x.m - align(x, y);
    lz = lead_zeros(diff);
    r = '0;
    if (diff != '0) begin
      r.m = diff << lz;
      r.e = x.e - exp_t'(lz);
    end
    return r;
  endfunction

  function automatic logic fge(input flt_t x, input flt_t y);
    logic res;
    if (x.m == '0) res = (y.m == '0);
    else if (y.m == '0) res = 1'b1;
    else if (x.e != y.e) res = (x.e > y.e);
    else res = (x.m >= y.m);
    return res;
  endfunction

  function automatic logic [63:0] sqrt_in(input flt_t x);
    return x.e[0] ? {1'b0, x.m, 31'd0} : {x.m, 32'd0};
  endfunction

  function automatic flt_t sqrt_out(input flt_t x, input logic [31:0] root);
    flt_t r;
    exp_t ea;
    ea = x.e[0] ? x.e - exp_t'(31) : x.e - exp_t'(32);
    r = '0;
    if (x.m != '0) begin
      r.m = root;
      r.e = ea >>> 1;
    end
    return r;
  endfunction

  function automatic flt_t div_out(input flt_t x, input flt_t y, input logic [32:0] q);
    flt_t r;
    exp_t e;
    e = x.e - y.e - exp_t'(32);
    r = '0;
    if (x.m != '0 && y.m != '0) begin
      if (q[32]) begin
        r.m = q[32:1];
        r.e = e + exp_t'(1);
      end else begin
        r.m = q[31:0];
        r.e = e;
      end
    end
    return r;
  endfunction

  // returns {value, status}
  function automatic logic [33:0] emit(input flt_t res, input logic neg);
    exp_t        sh;
    exp_t        nsh;
    logic [63:0] raw;
    logic [63:0] lim;
    logic        sat;
    logic [31:0] val;
    sh = res.e + exp_t'(FRAC_BITS);
    nsh = -sh;
    sat = 1'b0;
    raw = '0;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    if (res.m == '0) raw = '0;
    else if (sh > exp_t'(32)) sat = 1'b1;
    else if (sh >= exp_t'(0)) raw = {32'd0, res.m} << sh[5:0];
    else if (sh < exp_t'(-31)) raw = '0;
    else raw = {32'd0, res.m >> nsh[4:0]};
    if (sat || raw > lim) begin
      raw = lim;
      sat = 1'b1;
    end
    val = neg ? (~raw[31:0]) + 32'd1 : raw[31:0];
    return {val, sat ? ST_SAT : ST_OK};
  endfunction

endpackage

### rtl/core/dpfe_div_cell.sv
`timescale 1ns / 1ps
module dpfe_div_cell import dpfe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  ctx_t      in_ctx,
  input  div_work_t in_work,
  output logic      out_valid,
  output ctx_t      out_ctx,
  output div_work_t out_work
);

  logic        take;
  logic [32:0] rest;
  div_work_t   work_next;

  // one quotient bit per cell, restoring
  always_comb begin
    take = in_work.w >= {1'b0, in_work.y};
    rest = take ? in_work.w - {1'b0, in_work.y} : in_work.w;
    work_next.w = {rest[31:0], 1'b0};
    work_next.y = in_work.y;
    work_next.q = {in_work.q[31:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_ctx  <= in_ctx;
    out_work <= work_next;
  end

endmodule

### rtl/core/dpfe_sqrt_cell.sv
`timescale 1ns / 1ps
module dpfe_sqrt_cell import dpfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  ctx_t       in_ctx,
  input  sqrt_work_t in_work,
  output logic       out_valid,
  output ctx_t       out_ctx,
  output sqrt_work_t out_work
);

  logic [33:0] cur;
  logic [33:0] trial;
  logic        take;
  sqrt_work_t  work_next;

  // one root bit per cell, two radicand bits consumed
  always_comb begin
    cur = {in_work.rem[31:0], in_work.v[63:62]};
    trial = {in_work.root, 2'b01};
    take = cur >= trial;
    work_next.rem = take ? cur - trial : cur;
    work_next.root = {in_work.root[30:0], take};
    work_next.v = {in_work.v[61:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_ctx  <= in_ctx;
    out_work <= work_next;
  end

endmodule

### rtl/core/disk_potential_force_eval.sv
`timescale 1ns / 1ps
`include "disk_potential_force_eval_assert.svh"
// Disk potential and force evaluator, fully pipelined: one item is taken on every clock
// (busy stays low) and its result appears on value/status with a one-cycle done strobe.
// The pipeline is made of two 32-cell square-root chains and two 33-cell divider chains,
// each cell resolving one result bit per cycle, plus nine stages of multiply/add/format
// logic. Results cannot be held off: the receiver must take each one when done is high.
// Register writes go straight to the registers with no interlock, so write only when no
// item is in flight.
// status 0 ok, 1 saturated, 2 undefined (value zero).
module disk_potential_force_eval import dpfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [31:0] radius,
  input  logic [31:0] height,
  output logic        done,
  output logic [31:0] value,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // configuration registers
  logic [31:0] amplitude;
  logic [30:0] radial_scale;
  logic [30:0] height_scale;

  // pipeline stages outside the chains
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid, s8_valid;
  ctx_t s1, s2, s3, s4, s5, s6, s7, s8;
  ctx_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next, s8_next;

  // chain a: sqrt(z^2 + b^2)
  logic       a_valid [SQRT_STEPS+1];
  ctx_t       a_ctx   [SQRT_STEPS+1];
  sqrt_work_t a_work  [SQRT_STEPS+1];
  // chain b: (a + s) / s
  logic       b_valid [DIV_STEPS+1];
  ctx_t       b_ctx   [DIV_STEPS+1];
  div_work_t  b_work  [DIV_STEPS+1];
  // chain c: sqrt(D)
  logic       c_valid [SQRT_STEPS+1];
  ctx_t       c_ctx   [SQRT_STEPS+1];
  sqrt_work_t c_work  [SQRT_STEPS+1];
  // chain d: final quotient
  logic       d_valid [DIV_STEPS+1];
  ctx_t       d_ctx   [DIV_STEPS+1];
  div_work_t  d_work  [DIV_STEPS+1];

  // operands picked for the final quotient
  ctx_t        d_in;

  logic [33:0] out_word;
  logic        out_neg;
  flt_t        res;

  // never stalls
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude    <= AMP_RESET;
      radial_scale <= RADIAL_RESET;
      height_scale <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_AMPLITUDE: amplitude <= cfg_wdata;
        REG_RADIAL:    radial_scale <= cfg_wdata[30:0];
        REG_HEIGHT:    height_scale <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // stage 1: split signs, normalize operands
  always_comb begin
    s1_next = '0;
    s1_next.op = op;
    s1_next.undef = (op > OP_PR2);
    s1_next.aneg = amplitude[WORD_BITS-1];
    s1_next.rneg = radius[WORD_BITS-1];
    s1_next.zneg = height[WORD_BITS-1];
    s1_next.amp = from_mag(mag_of(amplitude));
    s1_next.r = from_mag(mag_of(radius));
    s1_next.z = from_mag(mag_of(height));
    s1_next.a = from_mag({1'b0, radial_scale});
    s1_next.b = from_mag({1'b0, height_scale});
  end

  // stage 2: squares
  always_comb begin
    s2_next = s1;
    s2_next.r2 = fmul(s1.r, s1.r);
    s2_next.z2 = fmul(s1.z, s1.z);
    s2_next.b2 = fmul(s1.b, s1.b);
  end

  // stage 3: z^2 + b^2
  always_comb begin
    s3_next = s2;
    s3_next.t = fadd(s2.z2, s2.b2);
  end

  assign a_valid[0] = s3_valid;
  assign a_ctx[0]   = s3;
  assign a_work[0]  = '{v: sqrt_in(s3.t), rem: '0, root: '0};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_chain_a
    dpfe_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (a_valid[k]),
      .in_ctx    (a_ctx[k]),
      .in_work   (a_work[k]),
      .out_valid (a_valid[k+1]),
      .out_ctx   (a_ctx[k+1]),
      .out_work  (a_work[k+1])
    );
  end

  // stage 4: s, and a + s (planar ops use a + b)
  always_comb begin
    flt_t s_val;
    s_val = sqrt_out(a_ctx[SQRT_STEPS].t, a_work[SQRT_STEPS].root);
    s4_next = a_ctx[SQRT_STEPS];
    s4_next.s = s_val;
    if (a_ctx[SQRT_STEPS].op <= OP_FZ) begin
      s4_next.as = fadd(a_ctx[SQRT_STEPS].a, s_val);
    end else begin
      s4_next.as = fadd(a_ctx[SQRT_STEPS].a, a_ctx[SQRT_STEPS].b);
    end
  end

  assign b_valid[0] = s4_valid;
  assign b_ctx[0]   = s4;
  assign b_work[0]  = '{w: {1'b0, s4.as.m}, y: s4.s.m, q: '0};

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_chain_b
    dpfe_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (b_valid[k]),
      .in_ctx    (b_ctx[k]),
      .in_work   (b_work[k]),
      .out_valid (b_valid[k+1]),
      .out_ctx   (b_ctx[k+1]),
      .out_work  (b_work[k+1])
    );
  end

  // stage 5: ratio, (a + s)^2
  always_comb begin
    s5_next = b_ctx[DIV_STEPS];
    s5_next.ratio = div_out(b_ctx[DIV_STEPS].as, b_ctx[DIV_STEPS].s, b_work[DIV_STEPS].q);
    s5_next.as2 = fmul(b_ctx[DIV_STEPS].as, b_ctx[DIV_STEPS].as);
  end

  // stage 6: denominator and the undefined cases
  always_comb begin
    flt_t den_val;
    den_val = fadd(s5.r2, s5.as2);
    s6_next = s5;
    s6_next.den = den_val;
    if (den_val.m == '0) s6_next.undef = 1'b1;
    // vertical force on the plane with a nonzero scale length
    if (s5.op == OP_FZ && s5.a.m != '0 && s5.s.m == '0) s6_next.undef = 1'b1;
  end

  assign c_valid[0] = s6_valid;
  assign c_ctx[0]   = s6;
  assign c_work[0]  = '{v: sqrt_in(s6.den), rem: '0, root: '0};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_chain_c
    dpfe_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[k]),
      .in_ctx    (c_ctx[k]),
      .in_work   (c_work[k]),
      .out_valid (c_valid[k+1]),
      .out_ctx   (c_ctx[k+1]),
      .out_work  (c_work[k+1])
    );
  end

  // stage 7: sqrt(D), D^1.5, amp products, D^2, (a+b)^2 - 2R^2
  always_comb begin
    flt_t sd_val;
    flt_t q2;
    logic ge;
    sd_val = sqrt_out(c_ctx[SQRT_STEPS].den, c_work[SQRT_STEPS].root);
    q2 = c_ctx[SQRT_STEPS].r2;
    if (q2.m != '0) q2.e = q2.e + exp_t'(1);
    ge = fge(c_ctx[SQRT_STEPS].as2, q2);
    s7_next = c_ctx[SQRT_STEPS];
    s7_next.sd = sd_val;
    s7_next.d3 = fmul(c_ctx[SQRT_STEPS].den, sd_val);
    s7_next.ar = fmul(c_ctx[SQRT_STEPS].amp, c_ctx[SQRT_STEPS].r);
    s7_next.az = fmul(c_ctx[SQRT_STEPS].amp, c_ctx[SQRT_STEPS].z);
    s7_next.dd = fmul(c_ctx[SQRT_STEPS].den, c_ctx[SQRT_STEPS].den);
    s7_next.dneg = !ge;
    s7_next.diff = ge ? fsub(c_ctx[SQRT_STEPS].as2, q2) : fsub(q2, c_ctx[SQRT_STEPS].as2);
  end

  // stage 8: second-level products
  always_comb begin
    s8_next = s7;
    s8_next.d5 = fmul(s7.dd, s7.sd);
    s8_next.ad = fmul(s7.amp, s7.diff);
    s8_next.num2 = fmul(s7.az, s7.ratio);
  end

  // operand select for the final quotient
  always_comb begin
    d_in = s8;
    case (s8.op)
      OP_POT: begin
        d_in.num = s8.amp;
        d_in.dnm = s8.sd;
      end
      OP_FR, OP_PFR: begin
        d_in.num = s8.ar;
        d_in.dnm = s8.d3;
      end
      OP_FZ: begin
        // zero scale length: the (a + s) / s factor is exactly one
        d_in.num = (s8.a.m != '0) ? s8.num2 : s8.az;
        d_in.dnm = s8.d3;
      end
      default: begin
        d_in.num = s8.ad;
        d_in.dnm = s8.d5;
      end
    endcase
  end

  assign d_valid[0] = s8_valid;
  assign d_ctx[0]   = d_in;
  assign d_work[0]  = '{w: {1'b0, d_in.num.m}, y: d_in.dnm.m, q: '0};

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_chain_d
    dpfe_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (d_valid[k]),
      .in_ctx    (d_ctx[k]),
      .in_work   (d_work[k]),
      .out_valid (d_valid[k+1]),
      .out_ctx   (d_ctx[k+1]),
      .out_work  (d_work[k+1])
    );
  end

  // sign, saturation and fixed-point format
  always_comb begin
    res = div_out(d_ctx[DIV_STEPS].num, d_ctx[DIV_STEPS].dnm, d_work[DIV_STEPS].q);
    case (d_ctx[DIV_STEPS].op)
      OP_POT:        out_neg = !d_ctx[DIV_STEPS].aneg;
      OP_FR, OP_PFR: out_neg = !(d_ctx[DIV_STEPS].aneg ^ d_ctx[DIV_STEPS].rneg);
      OP_FZ:         out_neg = !(d_ctx[DIV_STEPS].aneg ^ d_ctx[DIV_STEPS].zneg);
      default:       out_neg = d_ctx[DIV_STEPS].aneg ^ d_ctx[DIV_STEPS].dneg;
    endcase
    if (res.m == '0) out_neg = 1'b0;
    out_word = emit(res, out_neg);
    if (d_ctx[DIV_STEPS].undef) out_word = {32'd0, ST_UNDEF};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= a_valid[SQRT_STEPS];
      s5_valid <= b_valid[DIV_STEPS];
      s6_valid <= s5_valid;
      s7_valid <= c_valid[SQRT_STEPS];
      s8_valid <= s7_valid;
      done     <= d_valid[DIV_STEPS];
    end
    s1     <= s1_next;
    s2     <= s2_next;
    s3     <= s3_next;
    s4     <= s4_next;
    s5     <= s5_next;
    s6     <= s6_next;
    s7     <= s7_next;
    s8     <= s8_next;
    value  <= out_word[33:2];
    status <= out_word[1:0];
  end

  // every accepted item comes out after the fixed latency, and nothing else does
  `DPFE_ASSERT_AFTER(a_item_delivered, start && !busy, LATENCY, done, "item result missing")
  `DPFE_ASSERT_IMPLY(a_no_stray_result, done, $past(start && !busy, LATENCY), "stray result")
  `DPFE_ASSERT_IMPLY(a_undef_is_zero, done && status == ST_UNDEF, value == '0, "undef nonzero")

endmodule
